/* rtl/core/arts_pkg.sv */
// shared types and constants for the audio ring tap span reader
// no dependencies; imported by every module of the block
package arts_pkg;

   localparam int RING_FRAMES = 65536;
   localparam int MAX_SPAN    = 64;
   localparam int SAMPLE_BITS = 24;
   localparam int POS_W       = 48;
   localparam int CNT_W       = 7;
   localparam int LOG2_W      = 5;
   localparam int RING_AW     = $clog2(RING_FRAMES);
   localparam int LOG2_MIN    = 6;
   localparam int LOG2_RESET  = 16;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef enum logic [1:0] {
      OP_WRITE  = 2'd0,
      OP_SPAN   = 2'd1,
      OP_REFUSE = 2'd2
   } op_code_type;

   typedef enum logic [1:0] {
      KIND_PASS   = 2'd0,
      KIND_SPAN   = 2'd1,
      KIND_REFUSE = 2'd2
   } result_kind_type;

   typedef struct packed {
      op_code_type                    op;
      logic signed [SAMPLE_BITS-1:0]  left;
      logic signed [SAMPLE_BITS-1:0]  right;
      logic [RING_AW-1:0]             addr;
      logic [RING_AW-1:0]             mask;
      logic [CNT_W-1:0]               count;
      logic [POS_W-1:0]               frames_written;
   } op_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

/* rtl/core/arts_queue.sv */
// short in-order queue of classified items between front and back
// depends on arts_pkg
module arts_queue
   import arts_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  op_entry_type     push_entry,
   input  logic             pop,
   output op_entry_type     head,
   output queue_status_type status
);

   op_entry_type          slot_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]     fill_ff, fill_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (push && !pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop && !push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head         = slot_ff[rd_ptr_ff];
   assign status.full  = (fill_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign status.empty = (fill_ff == '0);

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !status.full) else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !status.empty) else $error("pop from empty queue");
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= (QUEUE_AW+1)'(QUEUE_DEPTH)) else $error("queue fill out of range");
`endif

endmodule

/* rtl/core/arts_front.sv */
// front end: accepts items, keeps the write position and ring size, checks spans
// depends on arts_pkg
module arts_front
   import arts_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [LOG2_W-1:0]             csr_ring_size_log2,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_right_sample,
   input  logic [POS_W-1:0]              req_read_start,
   input  logic [CNT_W-1:0]              req_read_count,
   input  queue_status_type              q_status,
   output logic                          push,
   output op_entry_type                  push_entry
);

   logic [LOG2_W-1:0] log2_ff, log2_in;
   logic [POS_W-1:0]  wpos_ff, wpos_in;
   logic [LOG2_W-1:0] log2_eff;
   logic [POS_W-1:0]  cap;
   logic [RING_AW-1:0] mask;
   logic [POS_W:0]    span_end;
   logic [POS_W-1:0]  back_dist;
   logic              refuse;

   assign csr_ready = 1'b1;
   assign req_stall = q_status.full;
   assign push      = req_valid && !q_status.full;

   always_comb begin
      log2_eff = log2_ff;
      if (log2_ff < LOG2_W'(LOG2_MIN)) begin
         log2_eff = LOG2_W'(LOG2_MIN);
      end else if (log2_ff > LOG2_W'(RING_AW)) begin
         log2_eff = LOG2_W'(RING_AW);
      end
      cap       = POS_W'(1) << log2_eff;
      mask      = RING_AW'(((RING_AW+1)'(1) << log2_eff) - 1'b1);
      span_end  = {1'b0, req_read_start} + (POS_W+1)'(req_read_count);
      back_dist = wpos_ff - req_read_start;
      refuse    = (req_read_count == '0)
               || (req_read_count > CNT_W'(MAX_SPAN))
               || (span_end > {1'b0, wpos_ff})
               || (back_dist > cap);
   end

   always_comb begin
      push_entry.left           = req_left_sample;
      push_entry.right          = req_right_sample;
      push_entry.mask           = mask;
      push_entry.count          = req_read_count;
      if (!req_command) begin
         push_entry.op             = OP_WRITE;
         push_entry.addr           = wpos_ff[RING_AW-1:0] & mask;
         push_entry.frames_written = wpos_ff + 1'b1;
      end else begin
         push_entry.op             = refuse ? OP_REFUSE : OP_SPAN;
         push_entry.addr           = req_read_start[RING_AW-1:0] & mask;
         push_entry.frames_written = wpos_ff;
      end
   end

   always_comb begin
      log2_in = log2_ff;
      wpos_in = wpos_ff;
      if (csr_valid && csr_ready) begin
         log2_in = csr_ring_size_log2;
         wpos_in = '0;
      end else if (push && !req_command) begin
         wpos_in = wpos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         log2_ff <= LOG2_W'(LOG2_RESET);
         wpos_ff <= '0;
      end else begin
         log2_ff <= log2_in;
         wpos_ff <= wpos_in;
      end
   end

endmodule

/* rtl/core/arts_back.sv */
// back end: frame ring memory, span sequencer and registered result stage
// depends on arts_pkg
module arts_back
   import arts_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  op_entry_type                  head,
   input  queue_status_type              q_status,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_result_kind,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_left,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_right,
   output logic                          rsp_last_of_run,
   output logic [POS_W-1:0]              rsp_frames_written
);

   logic [2*SAMPLE_BITS-1:0] ring [RING_FRAMES];
   logic [2*SAMPLE_BITS-1:0] rdata_ff;

   // span in progress
   logic               busy_ff, busy_in;
   logic [RING_AW-1:0] addr_ff, addr_in;
   logic [RING_AW-1:0] mask_ff, mask_in;
   logic [CNT_W-1:0]   remain_ff, remain_in;
   logic [POS_W-1:0]   fw_ff, fw_in;

   // read stage
   logic                          p1_valid_ff, p1_valid_in;
   result_kind_type               p1_kind_ff, p1_kind_in;
   logic signed [SAMPLE_BITS-1:0] p1_left_ff, p1_left_in;
   logic signed [SAMPLE_BITS-1:0] p1_right_ff, p1_right_in;
   logic                          p1_last_ff, p1_last_in;
   logic [POS_W-1:0]              p1_fw_ff, p1_fw_in;

   // result stage
   logic                          rsp_valid_ff, rsp_valid_in;
   result_kind_type               rsp_kind_ff, rsp_kind_in;
   logic signed [SAMPLE_BITS-1:0] rsp_left_ff, rsp_left_in;
   logic signed [SAMPLE_BITS-1:0] rsp_right_ff, rsp_right_in;
   logic                          rsp_last_ff, rsp_last_in;
   logic [POS_W-1:0]              rsp_fw_ff, rsp_fw_in;

   logic               p1_move;
   logic               adv;
   logic               mem_we;
   logic               mem_re;
   logic [RING_AW-1:0] mem_addr;

   assign p1_move  = p1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign adv      = !p1_valid_ff || p1_move;
   assign pop      = adv && !busy_ff && !q_status.empty;
   assign mem_we   = pop && (head.op == OP_WRITE);
   assign mem_re   = adv && (busy_ff || (!q_status.empty && head.op == OP_SPAN));
   assign mem_addr = busy_ff ? addr_ff : head.addr;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring[mem_addr] <= {head.left, head.right};
      end
      if (mem_re) begin
         rdata_ff <= ring[mem_addr];
      end
   end

   always_comb begin
      busy_in     = busy_ff;
      addr_in     = addr_ff;
      mask_in     = mask_ff;
      remain_in   = remain_ff;
      fw_in       = fw_ff;
      p1_valid_in = p1_valid_ff;
      p1_kind_in  = p1_kind_ff;
      p1_left_in  = p1_left_ff;
      p1_right_in = p1_right_ff;
      p1_last_in  = p1_last_ff;
      p1_fw_in    = p1_fw_ff;
      if (adv) begin
         p1_valid_in = 1'b0;
         if (busy_ff) begin
            p1_valid_in = 1'b1;
            p1_kind_in  = KIND_SPAN;
            p1_last_in  = (remain_ff == CNT_W'(1));
            p1_fw_in    = fw_ff;
            addr_in     = (addr_ff + 1'b1) & mask_ff;
            remain_in   = remain_ff - 1'b1;
            busy_in     = (remain_ff != CNT_W'(1));
         end else if (pop) begin
            p1_valid_in = 1'b1;
            p1_fw_in    = head.frames_written;
            p1_left_in  = head.left;
            p1_right_in = head.right;
            p1_last_in  = 1'b1;
            unique case (head.op)
               OP_WRITE: begin
                  p1_kind_in = KIND_PASS;
               end
               OP_SPAN: begin
                  p1_kind_in = KIND_SPAN;
                  p1_last_in = (head.count == CNT_W'(1));
                  busy_in    = (head.count != CNT_W'(1));
                  addr_in    = (head.addr + 1'b1) & head.mask;
                  mask_in    = head.mask;
                  remain_in  = head.count - 1'b1;
                  fw_in      = head.frames_written;
               end
               default: begin
                  p1_kind_in  = KIND_REFUSE;
                  p1_left_in  = '0;
                  p1_right_in = '0;
               end
            endcase
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_left_in  = rsp_left_ff;
      rsp_right_in = rsp_right_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_fw_in    = rsp_fw_ff;
      if (p1_move) begin
         rsp_valid_in = 1'b1;
         rsp_kind_in  = p1_kind_ff;
         rsp_last_in  = p1_last_ff;
         rsp_fw_in    = p1_fw_ff;
         if (p1_kind_ff == KIND_SPAN) begin
            rsp_left_in  = rdata_ff[2*SAMPLE_BITS-1:SAMPLE_BITS];
            rsp_right_in = rdata_ff[SAMPLE_BITS-1:0];
         end else begin
            rsp_left_in  = p1_left_ff;
            rsp_right_in = p1_right_ff;
         end
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         p1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         p1_valid_ff  <= p1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      mask_ff      <= mask_in;
      remain_ff    <= remain_in;
      fw_ff        <= fw_in;
      p1_kind_ff   <= p1_kind_in;
      p1_left_ff   <= p1_left_in;
      p1_right_ff  <= p1_right_in;
      p1_last_ff   <= p1_last_in;
      p1_fw_ff     <= p1_fw_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_left_ff  <= rsp_left_in;
      rsp_right_ff <= rsp_right_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_fw_ff    <= rsp_fw_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_kind    = rsp_kind_ff;
   assign rsp_out_left       = rsp_left_ff;
   assign rsp_out_right      = rsp_right_ff;
   assign rsp_last_of_run    = rsp_last_ff;
   assign rsp_frames_written = rsp_fw_ff;

`ifndef SYNTHESIS
   a_busy_has_frames: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (remain_ff != '0)) else $error("span active with nothing left");
   a_no_pop_mid_span: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !pop) else $error("queue popped during a span");
`endif

endmodule

/* rtl/core/audio_ring_tap_span_reader.sv */
// top level of the stereo audio tap with capture ring and span reads
// depends on arts_pkg, arts_front, arts_queue, arts_back
//
// usage
//   req channel (valid/stall): req_command 0 writes one stereo frame, which is
//   passed straight back as a result and stored in the ring; req_command 1
//   asks for req_read_count frames from absolute position req_read_start.
//   rsp channel (valid/stall): one result per write, one per frame of a good
//   span with rsp_last_of_run on the final one, or a single refusal result.
//   csr channel (valid/ready): writes ring_size_log2 and clears the write
//   position; write it only while no item is in flight.
// behaviour
//   an item's first result passes the queue, read stage and result stage
//   registers; while rsp is not stalled the back end issues one ring access
//   per cycle, so results stream at one per cycle; a span holds the back end
//   to its last frame while the four-entry queue keeps taking new items.
//   reset empties the queue and result stage, zeroes the write position and
//   sets the ring to 2^16 frames; ring contents are unknown until written.
//   while rsp_stall is high the result holds and the pipeline backs up into
//   the queue; req_stall rises when the queue is full.
module audio_ring_tap_span_reader
   import arts_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [LOG2_W-1:0]             csr_ring_size_log2,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_command,
   input  logic signed [SAMPLE_BITS-1:0] req_left_sample,
   input  logic signed [SAMPLE_BITS-1:0] req_right_sample,
   input  logic [POS_W-1:0]              req_read_start,
   input  logic [CNT_W-1:0]              req_read_count,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [1:0]                    rsp_result_kind,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_left,
   output logic signed [SAMPLE_BITS-1:0] rsp_out_right,
   output logic                          rsp_last_of_run,
   output logic [POS_W-1:0]              rsp_frames_written
);

   queue_status_type q_status;
   op_entry_type     push_entry;
   op_entry_type     head;
   logic             push;
   logic             pop;

   arts_front u_front (
      .clock              (clock),
      .reset              (reset),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_ring_size_log2 (csr_ring_size_log2),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_command        (req_command),
      .req_left_sample    (req_left_sample),
      .req_right_sample   (req_right_sample),
      .req_read_start     (req_read_start),
      .req_read_count     (req_read_count),
      .q_status           (q_status),
      .push               (push),
      .push_entry         (push_entry)
   );

   arts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .status     (q_status)
   );

   arts_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .q_status           (q_status),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_kind    (rsp_result_kind),
      .rsp_out_left       (rsp_out_left),
      .rsp_out_right      (rsp_out_right),
      .rsp_last_of_run    (rsp_last_of_run),
      .rsp_frames_written (rsp_frames_written)
   );

endmodule

/* verif/tb_audio_ring_tap_span_reader.sv */
// testbench for audio_ring_tap_span_reader: directed and random writes and span reads
// against a cycle-free predictor of the tap and its capture ring, with random stalls
// depends on arts_pkg and the rtl of audio_ring_tap_span_reader
module tb_audio_ring_tap_span_reader;
   import arts_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic CMD_WRITE    = 1'b0;
   localparam logic CMD_READ     = 1'b1;
   localparam int   LOG2_TOP     = 20;
   localparam int   HOLD_CYCLES  = 80;
   localparam int   DRAIN_CYCLES = 6;
   localparam int   TIMEOUT_NS   = 20_000_000;

   typedef struct {
      logic                          cmd;
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
      logic [POS_W-1:0]              start;
      logic [CNT_W-1:0]              count;
   } tap_request_type;

   typedef struct {
      result_kind_type               kind;
      logic signed [SAMPLE_BITS-1:0] left;
      logic signed [SAMPLE_BITS-1:0] right;
      logic                          last;
      logic [POS_W-1:0]              frames;
   } tap_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [LOG2_W-1:0]             csr_ring_size_log2 = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic                          req_command = CMD_WRITE;
   logic signed [SAMPLE_BITS-1:0] req_left_sample = '0;
   logic signed [SAMPLE_BITS-1:0] req_right_sample = '0;
   logic [POS_W-1:0]              req_read_start = '0;
   logic [CNT_W-1:0]              req_read_count = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [1:0]                    rsp_result_kind;
   logic signed [SAMPLE_BITS-1:0] rsp_out_left;
   logic signed [SAMPLE_BITS-1:0] rsp_out_right;
   logic                          rsp_last_of_run;
   logic [POS_W-1:0]              rsp_frames_written;

   audio_ring_tap_span_reader dut (.*);

   // predictor state
   logic [SAMPLE_BITS-1:0] ring_left [RING_FRAMES];
   logic [SAMPLE_BITS-1:0] ring_right [RING_FRAMES];
   logic [POS_W-1:0]       model_wpos = '0;
   logic [LOG2_W-1:0]      ring_log2 = LOG2_W'(LOG2_RESET);
   tap_result_type         outputs_due[$];

   // stimulus state
   tap_request_type pending[$];
   tap_request_type cur;
   longint unsigned gen_pos = 0;
   bit              offering = 1'b0;
   bit              req_took = 1'b0;
   int              gap_left = 0;
   bit              hold_req = 1'b0;
   int              hold_left = 0;
   int              stall_left = 0;
   int              free_left = 0;

   int n_writes = 0;
   int n_spans = 0;
   int n_refusals = 0;
   int n_checked = 0;
   int n_ring_sizes = 0;
   int mismatches = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("tb_audio_ring_tap_span_reader: errors");
      $finish;
   end

   function automatic longint unsigned ring_capacity(input logic [LOG2_W-1:0] lg);
      int              e;
      longint unsigned c;
      e = lg;
      if (e < LOG2_MIN) e = LOG2_MIN;
      if (e > LOG2_TOP) e = LOG2_TOP;
      c = 64'd1 << e;
      if (c > RING_FRAMES) c = RING_FRAMES;
      return c;
   endfunction

   function automatic void predict_tap_outputs(input logic cmd,
                                               input logic signed [SAMPLE_BITS-1:0] l,
                                               input logic signed [SAMPLE_BITS-1:0] r,
                                               input logic [POS_W-1:0] start,
                                               input logic [CNT_W-1:0] cnt);
      longint unsigned cap, w, s, idx;
      int              i;
      cap = ring_capacity(ring_log2);
      w = model_wpos;
      s = start;
      if (cmd == CMD_WRITE) begin
         idx = w & (cap - 1);
         ring_left[RING_AW'(idx)] = l;
         ring_right[RING_AW'(idx)] = r;
         model_wpos = model_wpos + 1'b1;
         outputs_due.push_back('{KIND_PASS, l, r, 1'b1, model_wpos});
         n_writes++;
      end else if (cnt == 0 || cnt > MAX_SPAN || s + cnt > w || w - s > cap) begin
         outputs_due.push_back('{KIND_REFUSE, '0, '0, 1'b1, model_wpos});
         n_refusals++;
      end else begin
         for (i = 0; i < cnt; i++) begin
            idx = (s + i) & (cap - 1);
            outputs_due.push_back('{KIND_SPAN, ring_left[RING_AW'(idx)],
                                    ring_right[RING_AW'(idx)],
                                    (i == cnt - 1), model_wpos});
         end
         n_spans++;
      end
   endfunction

   task automatic report(input string msg);
      mismatches++;
      if (mismatches <= 40) $display("%0t ns: %s", $time, msg);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_took) begin
            offering = 1'b0;
            gap_left = pick_gap();
         end
         if (!offering) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending.size() > 0) begin
               cur = pending.pop_front();
               offering = 1'b1;
               req_command <= cur.cmd;
               req_left_sample <= cur.left;
               req_right_sample <= cur.right;
               req_read_start <= cur.start;
               req_read_count <= cur.count;
            end
         end
         req_valid <= offering;
      end
   end

   // result receiver stalls
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (hold_req) begin
         hold_req = 1'b0;
         hold_left = HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (free_left > 0) begin
         free_left--;
         rsp_stall <= 1'b0;
      end else begin
         stall_left = pick_gap();
         free_left = ($urandom_range(0, 9) == 0) ? 40 : $urandom_range(0, 6);
         rsp_stall <= 1'b0;
      end
   end

   // monitor of both channels
   always @(posedge clock) begin : monitor
      tap_result_type want;
      req_took = !reset && req_valid && !req_stall;
      if (req_took)
         predict_tap_outputs(req_command, req_left_sample, req_right_sample,
                             req_read_start, req_read_count);
      if (!reset && rsp_valid && !rsp_stall) begin
         n_checked++;
         if (outputs_due.size() == 0) begin
            report($sformatf("result %0d arrived with nothing expected", n_checked));
         end else begin
            want = outputs_due.pop_front();
            if (rsp_result_kind !== want.kind || rsp_out_left !== want.left ||
                rsp_out_right !== want.right || rsp_last_of_run !== want.last ||
                rsp_frames_written !== want.frames)
               report($sformatf({"result %0d: got kind %0d L %h R %h last %b pos %0d, ",
                                 "want kind %0d L %h R %h last %b pos %0d"}, n_checked,
                                rsp_result_kind, rsp_out_left, rsp_out_right,
                                rsp_last_of_run, rsp_frames_written, want.kind,
                                want.left, want.right, want.last, want.frames));
         end
      end
   end

   task automatic push_write(input logic signed [SAMPLE_BITS-1:0] l,
                             input logic signed [SAMPLE_BITS-1:0] r);
      logic [63:0] junk;
      junk = {$urandom(), $urandom()};
      pending.push_back('{CMD_WRITE, l, r, junk[POS_W-1:0], junk[POS_W+CNT_W-1:POS_W]});
      gen_pos++;
   endtask

   task automatic push_read(input logic [POS_W-1:0] st, input logic [CNT_W-1:0] cnt);
      logic [31:0] a, b;
      a = $urandom();
      b = $urandom();
      pending.push_back('{CMD_READ, a[SAMPLE_BITS-1:0], b[SAMPLE_BITS-1:0], st, cnt});
   endtask

   task automatic drain();
      while (pending.size() != 0 || offering || outputs_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_ring_log2(input logic [LOG2_W-1:0] v);
      @(negedge clock);
      csr_ring_size_log2 <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      ring_log2 = v;
      model_wpos = '0;
      gen_pos = 0;
      n_ring_sizes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic queue_random(input int n, input int write_pct);
      int              k, roll, cnt;
      longint unsigned cap, avail, lo, hi, st;
      logic [31:0]     a, b;
      logic [63:0]     wide;
      @(posedge clock);
      cap = ring_capacity(ring_log2);
      for (k = 0; k < n; k++) begin
         roll = $urandom_range(0, 99);
         avail = (gen_pos < cap) ? gen_pos : cap;
         lo = gen_pos - avail;
         if (roll < write_pct) begin
            a = $urandom();
            b = $urandom();
            push_write(a[SAMPLE_BITS-1:0], b[SAMPLE_BITS-1:0]);
         end else if (roll < write_pct + (100 - write_pct) * 3 / 4 && gen_pos > 0) begin
            cnt = $urandom_range(1, (avail < MAX_SPAN) ? avail : MAX_SPAN);
            hi = gen_pos - cnt;
            st = ($urandom_range(0, 3) == 0) ? lo : lo + $urandom_range(0, hi - lo);
            push_read(POS_W'(st), CNT_W'(cnt));
         end else begin
            cnt = $urandom_range(1, MAX_SPAN);
            case ($urandom_range(0, 4))
               0: push_read(POS_W'(lo), '0);
               1: push_read(POS_W'(lo), CNT_W'($urandom_range(MAX_SPAN + 1, 127)));
               2: push_read(POS_W'(((gen_pos >= cnt) ? gen_pos - cnt : 0) + 1 +
                                   $urandom_range(0, 2)), CNT_W'(cnt));
               3: begin
                  if (gen_pos > cap)
                     push_read(POS_W'($urandom_range(0, gen_pos - cap - 1)), 7'd1);
                  else
                     push_read(POS_W'(gen_pos), 7'd1);
               end
               default: begin
                  wide = {$urandom(), $urandom()};
                  push_read(wide[POS_W-1:0], CNT_W'($urandom_range(0, 127)));
               end
            endcase
         end
      end
   endtask

   task automatic run_phase(input logic [LOG2_W-1:0] lg, input int n, input int write_pct,
                            input bit squeeze);
      write_ring_log2(lg);
      queue_random(n / 2, write_pct);
      if (squeeze) hold_req = 1'b1;
      drain();
      queue_random(n - n / 2, write_pct);
      drain();
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: sample extremes, refusals and spans at the reset ring size
      @(posedge clock);
      push_read(48'd0, 7'd1);
      push_write(24'sh7FFFFF, 24'sh800000);
      push_write(24'sh800000, 24'sh7FFFFF);
      push_write(24'sh000000, 24'shFFFFFF);
      push_write(24'shFFFFFF, 24'sh000000);
      push_write(24'sh555555, 24'shAAAAAA);
      push_read(48'd0, 7'd5);
      push_read(48'd0, 7'd0);
      push_read(48'd0, 7'd6);
      push_read(48'd4, 7'd1);
      push_read(48'hFFFF_FFFF_FFFE, 7'd4);
      push_read(48'hFFFF_FFFF_FFFF, 7'h7F);
      push_read(48'd0, CNT_W'(MAX_SPAN + 1));
      push_read(48'd1, 7'd2);
      push_read(48'd5, 7'd1);
      drain();

      // smallest ring gets enough writes to wrap, with a long receiver hold-off
      run_phase(5'd6, 84, 90, 1'b1);
      run_phase(5'd0, 4, 50, 1'b0);
      run_phase(5'd31, 4, 50, 1'b0);
      run_phase(5'd8, 4, 50, 1'b0);
      run_phase(5'd20, 4, 50, 1'b0);
      run_phase(5'd5, 4, 50, 1'b0);
      run_phase(5'd16, 4, 50, 1'b0);

      $display("run covered %0d frame writes, %0d span reads and %0d refused requests",
               n_writes, n_spans, n_refusals);
      $display("%0d results checked over %0d ring size settings, %0d mismatches",
               n_checked, n_ring_sizes, mismatches);
      if (mismatches == 0)
         $display("tb_audio_ring_tap_span_reader: clean");
      else
         $display("tb_audio_ring_tap_span_reader: errors");
      $finish;
   end

endmodule

/* files.f */
rtl/core/arts_pkg.sv
rtl/core/arts_queue.sv
rtl/core/arts_front.sv
rtl/core/arts_back.sv
rtl/core/audio_ring_tap_span_reader.sv
verif/tb_audio_ring_tap_span_reader.sv
